// ===== design/dnsq_pkg.sv =====
// shared types, phase codes and constants for the dns question parser
package dnsq_pkg;

    localparam int DNSQ_HEADER_BYTES = 12;
    localparam int DNSQ_QUEUE_DEPTH = 3;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_QTYPE  = 3'd3;
    localparam logic [2:0] PH_QCLASS = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [15:0] NAME_COUNT_MAX = 16'hFFFF;

    localparam int FLAG_NAME   = 0;
    localparam int FLAG_QTYPE  = 1;
    localparam int FLAG_QCLASS = 2;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  field_count;
        logic        qdcount_seen;
        logic [7:0]  label_remaining;
        logic        label_started;
        logic [15:0] name_count;
        logic [15:0] type_value;
        logic [15:0] class_value;
        logic [2:0]  presence_flags;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:           PH_HEADER,
        field_count:     4'd0,
        qdcount_seen:    1'b0,
        label_remaining: 8'd0,
        label_started:   1'b0,
        name_count:      16'd0,
        type_value:      16'd0,
        class_value:     16'd0,
        presence_flags:  3'd0
    };

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        logic        name_valid;
        logic [15:0] name_length;
        logic [15:0] qtype;
        logic        qtype_present;
        logic [15:0] qclass;
        logic        qclass_present;
        logic        run_last;
    } result_t;

endpackage

// ===== design/dnsq_parse.sv =====
// per-byte parse step: next parser state plus the character and summary results
module dnsq_parse
    import dnsq_pkg::*;
#(
    parameter int HEADER_BYTES = DNSQ_HEADER_BYTES
)
(
    input  parse_state_t st,
    input  logic [7:0]   message_byte,
    input  logic         final_byte,
    output parse_state_t st_next,
    output logic         char_valid,
    output result_t      char_res,
    output logic         sum_valid,
    output result_t      sum_res
);

    localparam logic [3:0] HEADER_LAST = 4'(HEADER_BYTES - 1);

    always_comb
    begin
        parse_state_t nx;
        logic         emit;
        logic [7:0]   ch;
        logic [7:0]   rem;
        logic [3:0]   fc;

        nx   = st;
        emit = 1'b0;
        ch   = 8'd0;
        rem  = st.label_remaining - 8'd1;
        fc   = st.field_count + 4'd1;

        unique case (st.phase)
            PH_HEADER:
            begin
                if ((st.field_count == 4'd4 || st.field_count == 4'd5) && message_byte != 8'd0)
                    nx.qdcount_seen = 1'b1;
                if (st.field_count >= HEADER_LAST)
                begin
                    nx.field_count = 4'd0;
                    nx.phase       = nx.qdcount_seen ? PH_LEN : PH_SKIP;
                end
                else
                begin
                    nx.field_count = fc;
                end
            end
            PH_LEN:
            begin
                if (message_byte == 8'd0)
                begin
                    nx.presence_flags[FLAG_NAME] = 1'b1;
                    nx.field_count = 4'd0;
                    nx.phase       = PH_QTYPE;
                end
                else
                begin
                    // separator ahead of every label but the first
                    if (st.label_started)
                    begin
                        emit = 1'b1;
                        ch   = DOT_CHAR;
                    end
                    nx.label_started   = 1'b1;
                    nx.label_remaining = message_byte;
                    nx.phase           = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                emit = 1'b1;
                ch   = message_byte;
                nx.label_remaining = rem;
                if (rem == 8'd0)
                    nx.phase = PH_LEN;
            end
            PH_QTYPE:
            begin
                nx.type_value  = {st.type_value[7:0], message_byte};
                nx.field_count = fc;
                if (fc >= 4'd2)
                begin
                    nx.presence_flags[FLAG_QTYPE] = 1'b1;
                    nx.field_count = 4'd0;
                    nx.phase       = PH_QCLASS;
                end
            end
            PH_QCLASS:
            begin
                nx.class_value = {st.class_value[7:0], message_byte};
                nx.field_count = fc;
                if (fc >= 4'd2)
                begin
                    nx.presence_flags[FLAG_QCLASS] = 1'b1;
                    nx.field_count = 4'd0;
                    nx.phase       = PH_SKIP;
                end
            end
            default:
            begin
                nx = st;
            end
        endcase

        if (emit && nx.name_count != NAME_COUNT_MAX)
            nx.name_count = nx.name_count + 16'd1;

        char_valid         = emit;
        char_res           = '0;
        char_res.kind      = KIND_CHAR;
        char_res.name_char = ch;
        char_res.run_last  = ~final_byte;

        sum_valid              = final_byte;
        sum_res                = '0;
        sum_res.kind           = KIND_SUMMARY;
        sum_res.name_valid     = nx.presence_flags[FLAG_NAME];
        sum_res.name_length    = nx.name_count;
        sum_res.qtype_present  = nx.presence_flags[FLAG_QTYPE];
        sum_res.qtype          = nx.presence_flags[FLAG_QTYPE] ? nx.type_value : 16'd0;
        sum_res.qclass_present = nx.presence_flags[FLAG_QCLASS];
        sum_res.qclass         = nx.presence_flags[FLAG_QCLASS] ? nx.class_value : 16'd0;
        sum_res.run_last       = 1'b1;

        // message done: start over for the next one
        st_next = final_byte ? PARSE_STATE_RESET : nx;
    end

endmodule

// ===== design/dnsq_res_queue.sv =====
// small shifting result queue: takes up to two results a cycle, hands out one
module dnsq_res_queue
    import dnsq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_a,
    input  result_t res_a,
    input  logic    push_b,
    input  result_t res_b,
    output logic    has_room,
    output logic    head_valid,
    output result_t head,
    input  logic    pop
);

    localparam int CW = $clog2(DNSQ_QUEUE_DEPTH + 1);

    result_t         slot_reg [DNSQ_QUEUE_DEPTH];
    result_t         slot_next[DNSQ_QUEUE_DEPTH];
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [CW-1:0]   base;
    logic            do_pop;

    assign do_pop     = pop && cnt_reg != '0;
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[0];
    // room for a worst case pair of results without looking at the output side
    assign has_room   = cnt_reg <= CW'(DNSQ_QUEUE_DEPTH - 2);
    assign base       = cnt_reg - CW'(do_pop);

    always_comb
    begin
        for (int i = 0; i < DNSQ_QUEUE_DEPTH; i++)
            slot_next[i] = slot_reg[i];
        if (do_pop)
        begin
            for (int i = 0; i < DNSQ_QUEUE_DEPTH - 1; i++)
                slot_next[i] = slot_reg[i + 1];
        end
        for (int i = 0; i < DNSQ_QUEUE_DEPTH; i++)
        begin
            if (push_a && base == CW'(i))
                slot_next[i] = res_a;
            if (push_b && base + CW'(1) == CW'(i))
                slot_next[i] = res_b;
        end
        cnt_next = base + CW'(push_a) + CW'(push_b);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DNSQ_QUEUE_DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DNSQ_QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_b_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
        push_b |-> push_a)
        else $error("second result pushed without first");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !push_a) |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("queue count wrong after pop");
`endif

endmodule

// ===== design/dns_question_parser.sv =====
// dns question parser top level: byte input, parser state, result queue
// Takes a DNS message one byte per request, with final_byte on its last byte, and gives
// the first question's name as character results ('.' between labels), then one summary
// result on the last byte with name validity, length, qtype and qclass. A byte is taken
// every cycle while the three-entry result queue has room for two results; a byte that
// yields both a character and the summary pushes two results at once, and results that are
// not popped while out_ready is low fill the queue and stop input until they are taken.
module dns_question_parser
    import dnsq_pkg::*;
#(
    parameter int HEADER_BYTES = DNSQ_HEADER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  message_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  name_char,
    output logic        name_valid,
    output logic [15:0] name_length,
    output logic [15:0] qtype,
    output logic        qtype_present,
    output logic [15:0] qclass,
    output logic        qclass_present,
    output logic        run_last
);

    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t st_step;
    logic         in_fire;
    logic         char_valid;
    logic         sum_valid;
    result_t      char_res;
    result_t      sum_res;
    result_t      head;
    logic         push_a;
    logic         push_b;
    result_t      res_a;

    assign in_fire = in_valid && in_ready;

    dnsq_parse #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parse (
        .st           (st_reg),
        .message_byte (message_byte),
        .final_byte   (final_byte),
        .st_next      (st_step),
        .char_valid   (char_valid),
        .char_res     (char_res),
        .sum_valid    (sum_valid),
        .sum_res      (sum_res)
    );

    assign st_next = in_fire ? st_step : st_reg;
    assign push_a  = in_fire && (char_valid || sum_valid);
    assign push_b  = in_fire && char_valid && sum_valid;
    assign res_a   = char_valid ? char_res : sum_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= PARSE_STATE_RESET;
        else
            st_reg <= st_next;
    end

    dnsq_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_a     (push_a),
        .res_a      (res_a),
        .push_b     (push_b),
        .res_b      (sum_res),
        .has_room   (in_ready),
        .head_valid (out_valid),
        .head       (head),
        .pop        (out_ready)
    );

    assign kind           = head.kind;
    assign name_char      = head.name_char;
    assign name_valid     = head.name_valid;
    assign name_length    = head.name_length;
    assign qtype          = head.qtype;
    assign qtype_present  = head.qtype_present;
    assign qclass         = head.qclass;
    assign qclass_present = head.qclass_present;
    assign run_last       = head.run_last;

`ifndef ASSERT_OFF
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && final_byte) |=> (st_reg.phase == PH_HEADER && st_reg.field_count == 4'd0
                                     && st_reg.name_count == 16'd0))
        else $error("parser state not cleared after last byte");

    a_label_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && st_reg.phase == PH_LABEL) |-> push_a)
        else $error("label byte gave no character");

    a_name_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !final_byte) |=> st_reg.name_count >= $past(st_reg.name_count))
        else $error("name count went backward inside a message");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SUMMARY) |-> run_last)
        else $error("summary result not marked last");
`endif

endmodule
